>>> rtl/core/deq_pkg.sv
package deq_pkg;

  // Storage geometry.
  localparam int unsigned DEPTH    = 64;
  localparam int unsigned IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned STATUS_W = 2;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Command codes carried by a request.
  typedef enum logic [CMD_W-1:0] {
    CMD_RESET_ONE  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_PUSH_BACK  = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_POP_BACK   = 3'd4,
    CMD_DISPLAY    = 3'd5
  } cmd_e;

  // Status codes returned with each result.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // Control states of the sequencer.
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DISP = 2'd1,
    ST_WAIT = 2'd2
  } state_e;

  // Ring position base + off, both below DEPTH.
  function automatic idx_t ring_add(input idx_t base, input idx_t off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (IDX_W + 1)'(DEPTH)) begin
      sum = sum - (IDX_W + 1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  // Ring position one step before base.
  function automatic idx_t ring_dec(input idx_t base);
    idx_t res;
    if (base == '0) begin
      res = IDX_W'(DEPTH - 1);
    end else begin
      res = base - IDX_W'(1);
    end
    return res;
  endfunction

endpackage

>>> rtl/core/double_ended_queue.sv
// Channel   Direction  Handshake                  Payload
// request   in         start, accepted if !busy   command_i, value_i
// result    out        done_o, one-cycle strobe   status_o, element_o, last_o
//
// Reset-to-one, pushes, and pops or displays on an empty list need no memory read;
// the result strobes in the cycle after the request.
// Pops make one memory read, whose data passes the memory's read register
// and then the result registers; a display streams one element per cycle.
// The single read port of the element memory sets the display rate.
// Reset empties the list at once; memory contents are not cleared.
// The receiver cannot stall; busy holds off new requests.
module double_ended_queue
  import deq_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [CMD_W-1:0]         command_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     done_o,
  output logic [STATUS_W-1:0]      status_o,
  output logic signed [DATA_W-1:0] element_o,
  output logic                     last_o
);

  state_e state_q, state_d;
  idx_t   head_q, head_d;
  cnt_t   count_q, count_d;
  idx_t   idx_q, idx_d;
  logic   rd_vld_q, rd_vld_d;
  logic   rd_last_q, rd_last_d;

  logic              done_q, done_d;
  status_e           status_q, status_d;
  logic [DATA_W-1:0] element_q, element_d;
  logic              last_q, last_d;

  logic              mem_we;
  idx_t              mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  idx_t              mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  logic accept;
  logic full;
  logic empty;
  cnt_t count_m1;
  logic disp_last;

  assign accept    = start && (state_q == ST_IDLE);
  assign full      = (count_q == CNT_W'(DEPTH));
  assign empty     = (count_q == '0);
  assign count_m1  = count_q - CNT_W'(1);
  assign disp_last = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);

  deq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // Sequencer: decode requests, update pointers, issue memory accesses.
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    count_d   = count_q;
    idx_d     = idx_q;
    rd_vld_d  = 1'b0;
    rd_last_d = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = value_i;
    mem_re    = 1'b0;
    mem_raddr = head_q;

    // A read issued last cycle lands here and becomes a result.
    done_d    = rd_vld_q;
    status_d  = STATUS_OK;
    element_d = rd_vld_q ? mem_rdata : '0;
    last_d    = rd_vld_q ? rd_last_q : 1'b1;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_e'(command_i))
            CMD_RESET_ONE: begin
              mem_we    = 1'b1;
              mem_waddr = '0;
              head_d    = '0;
              count_d   = CNT_W'(1);
              done_d    = 1'b1;
            end
            CMD_PUSH_FRONT: begin
              done_d = 1'b1;
              if (full) begin
                status_d = STATUS_FULL;
              end else begin
                head_d    = ring_dec(head_q);
                mem_we    = 1'b1;
                mem_waddr = ring_dec(head_q);
                count_d   = count_q + CNT_W'(1);
              end
            end
            CMD_PUSH_BACK: begin
              done_d = 1'b1;
              if (full) begin
                status_d = STATUS_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = ring_add(head_q, count_q[IDX_W-1:0]);
                count_d   = count_q + CNT_W'(1);
              end
            end
            CMD_POP_FRONT: begin
              if (empty) begin
                done_d   = 1'b1;
                status_d = STATUS_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = head_q;
                head_d    = ring_add(head_q, IDX_W'(1));
                count_d   = count_m1;
                rd_vld_d  = 1'b1;
                rd_last_d = 1'b1;
                state_d   = ST_WAIT;
              end
            end
            CMD_POP_BACK: begin
              if (empty) begin
                done_d   = 1'b1;
                status_d = STATUS_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = ring_add(head_q, count_m1[IDX_W-1:0]);
                count_d   = count_m1;
                rd_vld_d  = 1'b1;
                rd_last_d = 1'b1;
                state_d   = ST_WAIT;
              end
            end
            CMD_DISPLAY: begin
              if (empty) begin
                done_d   = 1'b1;
                status_d = STATUS_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = head_q;
                rd_vld_d  = 1'b1;
                if (count_q == CNT_W'(1)) begin
                  rd_last_d = 1'b1;
                  state_d   = ST_WAIT;
                end else begin
                  idx_d   = IDX_W'(1);
                  state_d = ST_DISP;
                end
              end
            end
            default: begin
              // Unused command codes are dropped without a result.
            end
          endcase
        end
      end
      ST_DISP: begin
        mem_re    = 1'b1;
        mem_raddr = ring_add(head_q, idx_q);
        rd_vld_d  = 1'b1;
        rd_last_d = disp_last;
        if (disp_last) begin
          state_d = ST_WAIT;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_WAIT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      head_q    <= '0;
      count_q   <= '0;
      idx_q     <= '0;
      rd_vld_q  <= 1'b0;
      rd_last_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      rd_vld_q  <= rd_vld_d;
      rd_last_q <= rd_last_d;
      done_q    <= done_d;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    element_q <= element_d;
    last_q    <= last_d;
  end

  assign busy      = (state_q != ST_IDLE);
  assign done_o    = done_q;
  assign status_o  = status_q;
  assign element_o = element_q;
  assign last_o    = last_q;

  // The element count never exceeds the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
  else $error("element count above capacity");

  // The head pointer stays inside the ring.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q < IDX_W'(DEPTH - 1) || head_q == IDX_W'(DEPTH - 1))
  else $error("head pointer outside ring");

  // Every memory read turns into a result strobe.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |=> done_q)
  else $error("memory read did not produce a result");

  // A display in progress walks only over stored elements.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DISP) |-> (CNT_W'(idx_q) < count_q))
  else $error("display index beyond element count");

  // A request that is not full and pushes grows the list by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !full && (command_i == CMD_PUSH_FRONT || command_i == CMD_PUSH_BACK))
    |=> (count_q == $past(count_q) + CNT_W'(1)))
  else $error("push did not grow the list");

endmodule

>>> rtl/core/deq_ram.sv
module deq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sim/tb_top.sv
module tb_top;
  import deq_pkg::*;

  // Command codes that the block ignores without any result.
  localparam logic [CMD_W-1:0] CMD_UNUSED_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_B = 3'd7;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned IDLE_PCT    = 22;
  localparam int unsigned TAIL_CYCLES = 8;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    status_e                   status;
    logic signed [DATA_W-1:0]  element;
    logic                      last;
  } deque_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [CMD_W-1:0]         command_i = '0;
  logic signed [DATA_W-1:0] value_i = '0;
  logic                     done_o;
  logic [STATUS_W-1:0]      status_o;
  logic signed [DATA_W-1:0] element_o;
  logic                     last_o;

  // Shadow copy of the ring buffer and its pointers.
  logic signed [DATA_W-1:0] shadow_store [DEPTH];
  idx_t                     shadow_head;
  cnt_t                     shadow_count;

  deque_result_t due_results [$];

  int unsigned cycle_count    = 0;
  int unsigned error_count    = 0;
  int unsigned request_count  = 0;
  int unsigned result_count   = 0;
  int unsigned display_count  = 0;
  int unsigned full_hits      = 0;
  int unsigned peak_count     = 0;
  bit          idling_enabled = 1'b1;

  double_ended_queue u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .command_i (command_i),
    .value_i   (value_i),
    .done_o    (done_o),
    .status_o  (status_o),
    .element_o (element_o),
    .last_o    (last_o)
  );

  // Free-running clock.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Guard against a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("double_ended_queue: mismatch");
      $finish;
    end
  end

  // Queue one expected result.
  function automatic void expect_result(status_e st, logic signed [DATA_W-1:0] elem,
                                        logic is_last);
    deque_result_t r;
    r.status  = st;
    r.element = elem;
    r.last    = is_last;
    due_results.push_back(r);
  endfunction

  // Ring position a given distance past the head.
  function automatic idx_t shadow_slot(int unsigned offset);
    return idx_t'((int'(shadow_head) + offset) % DEPTH);
  endfunction

  // Apply one accepted command to the shadow deque and predict its results.
  function automatic void apply_deque_command(logic [CMD_W-1:0] cmd,
                                              logic signed [DATA_W-1:0] val);
    logic signed [DATA_W-1:0] taken;
    case (cmd)
      CMD_RESET_ONE: begin
        shadow_head     = '0;
        shadow_store[0] = val;
        shadow_count    = cnt_t'(1);
        expect_result(STATUS_OK, '0, 1'b1);
      end
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (int'(shadow_count) >= DEPTH) begin
          full_hits++;
          expect_result(STATUS_FULL, '0, 1'b1);
        end else begin
          if (cmd == CMD_PUSH_FRONT) begin
            shadow_head = (shadow_head == '0) ? idx_t'(DEPTH - 1) : shadow_head - 1'b1;
            shadow_store[shadow_head] = val;
          end else begin
            shadow_store[shadow_slot(shadow_count)] = val;
          end
          shadow_count = shadow_count + 1'b1;
          expect_result(STATUS_OK, '0, 1'b1);
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (shadow_count == '0) begin
          expect_result(STATUS_EMPTY, '0, 1'b1);
        end else begin
          if (cmd == CMD_POP_FRONT) begin
            taken       = shadow_store[shadow_head];
            shadow_head = shadow_slot(1);
          end else begin
            taken = shadow_store[shadow_slot(shadow_count - 1'b1)];
          end
          shadow_count = shadow_count - 1'b1;
          expect_result(STATUS_OK, taken, 1'b1);
        end
      end
      CMD_DISPLAY: begin
        display_count++;
        if (shadow_count == '0) begin
          expect_result(STATUS_EMPTY, '0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < shadow_count; i++) begin
            expect_result(STATUS_OK, shadow_store[shadow_slot(i)], i + 1 == shadow_count);
          end
        end
      end
      default: begin
        // Undefined codes leave the deque untouched and answer nothing.
      end
    endcase
    if (shadow_count > peak_count) peak_count = shadow_count;
  endfunction

  // Drive one request, hold it until the block takes it, then maybe idle a while.
  task automatic issue_request(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] val);
    int unsigned gap;
    @(negedge clk_i);
    start     <= 1'b1;
    command_i <= cmd;
    value_i   <= val;
    do @(posedge clk_i); while (busy);
    request_count++;
    apply_deque_command(cmd, val);
    if (idling_enabled && $urandom_range(99) < IDLE_PCT) begin
      gap = $urandom_range(3);
      @(negedge clk_i);
      start     <= 1'b0;
      command_i <= CMD_W'($urandom);
      value_i   <= $urandom;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Values weighted toward the extremes of the signed range, zero and minus one.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  // Pops and displays on an empty list, plus the undefined codes.
  task automatic test_empty_list();
    issue_request(CMD_POP_FRONT, 32'sd5);
    issue_request(CMD_POP_BACK, VAL_MIN);
    issue_request(CMD_DISPLAY, VAL_MAX);
    issue_request(CMD_UNUSED_A, 32'sd1);
    issue_request(CMD_UNUSED_B, -1);
    issue_request(CMD_DISPLAY, '0);
  endtask

  // Extreme values through both ends, reset-to-one over a filled list.
  task automatic test_extreme_values();
    issue_request(CMD_RESET_ONE, VAL_MIN);
    issue_request(CMD_PUSH_FRONT, VAL_MAX);
    issue_request(CMD_PUSH_BACK, -1);
    issue_request(CMD_PUSH_BACK, '0);
    issue_request(CMD_PUSH_FRONT, 32'sd1);
    issue_request(CMD_DISPLAY, '0);
    issue_request(CMD_POP_FRONT, '0);
    issue_request(CMD_POP_BACK, '0);
    issue_request(CMD_UNUSED_B, 32'sh5555_5555);
    issue_request(CMD_DISPLAY, '0);
    issue_request(CMD_RESET_ONE, VAL_MAX);
    issue_request(CMD_DISPLAY, '0);
    issue_request(CMD_POP_BACK, '0);
    issue_request(CMD_POP_FRONT, '0);
    issue_request(CMD_PUSH_BACK, 32'sh5555_5555);
    issue_request(CMD_PUSH_FRONT, 32'sh2aaa_aaaa);
    issue_request(CMD_POP_BACK, '0);
    issue_request(CMD_POP_FRONT, '0);
  endtask

  // Fill to capacity from both ends, hit the full case, then drain past empty.
  task automatic test_fill_and_drain();
    issue_request(CMD_RESET_ONE, pick_value());
    repeat (DEPTH - 1) begin
      issue_request($urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, pick_value());
    end
    issue_request(CMD_PUSH_FRONT, pick_value());
    issue_request(CMD_PUSH_BACK, pick_value());
    issue_request(CMD_UNUSED_A, pick_value());
    issue_request(CMD_DISPLAY, pick_value());
    repeat (DEPTH + 1) begin
      issue_request($urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK, pick_value());
    end
    issue_request(CMD_DISPLAY, pick_value());
  endtask

  // Random command mix steered to keep the list mostly partly filled.
  task automatic test_random_mix(int unsigned n_items);
    int unsigned roll;
    int unsigned push_ceiling;
    for (int unsigned k = 0; k < n_items; k++) begin
      // A run of back-to-back requests in the middle of the mix.
      idling_enabled = !(k >= n_items / 3 && k < n_items / 3 + 60);
      roll = $urandom_range(99);
      push_ceiling = (shadow_count < 40) ? 62 : 38;
      if (roll < 3) begin
        issue_request($urandom_range(1) ? CMD_UNUSED_A : CMD_UNUSED_B, pick_value());
      end else if (roll < 6) begin
        issue_request(CMD_RESET_ONE, pick_value());
      end else if (roll < 13) begin
        issue_request(CMD_DISPLAY, pick_value());
      end else if (roll < push_ceiling) begin
        issue_request($urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, pick_value());
      end else begin
        issue_request($urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK, pick_value());
      end
    end
    idling_enabled = 1'b1;
  endtask

  // Compare every result strobe with the oldest expectation.
  always @(posedge clk_i) begin : check_results
    deque_result_t want;
    if (rst_ni && done_o) begin
      result_count++;
      if (due_results.size() == 0) begin
        error_count++;
        $error("unexpected result: status %0d element %0d last %0d",
               status_o, element_o, last_o);
      end else begin
        want = due_results.pop_front();
        if (status_o !== want.status) begin
          error_count++;
          $error("status: expected %0d, actual %0d", want.status, status_o);
        end
        if (element_o !== want.element) begin
          error_count++;
          $error("element: expected %0d, actual %0d", want.element, element_o);
        end
        if (last_o !== want.last) begin
          error_count++;
          $error("last: expected %0d, actual %0d", want.last, last_o);
        end
      end
    end
  end

  // Test sequence.
  initial begin
    shadow_head  = '0;
    shadow_count = '0;
    for (int i = 0; i < DEPTH; i++) shadow_store[i] = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_list();
    test_extreme_values();
    test_fill_and_drain();
    test_random_mix(112);

    @(negedge clk_i);
    start <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d requests and %0d results, %0d displays, %0d full rejects.",
             request_count, result_count, display_count, full_hits);
    $display("Deepest occupancy reached: %0d of %0d entries.", peak_count, DEPTH);
    if (error_count == 0 && due_results.size() == 0) begin
      $display("double_ended_queue: match");
    end else begin
      $display("double_ended_queue: mismatch");
    end
    $finish;
  end

endmodule
